// File: hw/rtl/cbif_pkg.sv
`timescale 1ns / 1ps

package cbif_pkg;

  localparam int unsigned CW      = 17;
  localparam int unsigned LW      = 16;
  localparam int unsigned KW      = 9;
  localparam int unsigned PW      = 2 * CW;
  localparam int unsigned DW      = 36;
  localparam int unsigned QW      = 17;
  localparam int unsigned N_DIV   = 5;

  localparam logic [2:0] REG_CROP_LEFT   = 3'd0;
  localparam logic [2:0] REG_CROP_TOP    = 3'd1;
  localparam logic [2:0] REG_CROP_RIGHT  = 3'd2;
  localparam logic [2:0] REG_CROP_BOTTOM = 3'd3;
  localparam logic [2:0] REG_MIN_IOU     = 3'd4;

  localparam logic [2:0] OP_IOU    = 3'd0;
  localparam logic [2:0] OP_LEFT   = 3'd1;
  localparam logic [2:0] OP_TOP    = 3'd2;
  localparam logic [2:0] OP_RIGHT  = 3'd3;
  localparam logic [2:0] OP_BOTTOM = 3'd4;

  localparam logic [CW-1:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;
    logic [CW-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic [CW-1:0] iw;
    logic [CW-1:0] ih;
    logic [CW-1:0] bw;
    logic [CW-1:0] bh;
    logic [CW-1:0] cw;
    logic [CW-1:0] ch;
    logic [CW-1:0] off_l;
    logic [CW-1:0] off_t;
    logic [CW-1:0] off_r;
    logic [CW-1:0] off_b;
    logic          kept;
    logic [LW-1:0] label;
    logic          last;
  } job_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [CW-1:0] iou_value;
    logic          iou_pass;
    logic          center_inside;
    logic [CW-1:0] norm_left;
    logic [CW-1:0] norm_top;
    logic [CW-1:0] norm_right;
    logic [CW-1:0] norm_bottom;
    logic [LW-1:0] class_id;
    logic          set_all_pass;
    logic [KW-1:0] set_kept_count;
    logic          result_last;
  } res_t;

  function automatic logic [CW-1:0] span(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    span = (hi > lo) ? (hi - lo) : '0;
  endfunction

  function automatic logic [CW-1:0] umax(input logic [CW-1:0] a, input logic [CW-1:0] b);
    umax = (a > b) ? a : b;
  endfunction

  function automatic logic [CW-1:0] umin(input logic [CW-1:0] a, input logic [CW-1:0] b);
    umin = (a < b) ? a : b;
  endfunction

  // offset of v clamped into [lo, hi], relative to lo
  function automatic logic [CW-1:0] clamp_off(input logic [CW-1:0] v,
                                              input logic [CW-1:0] lo,
                                              input logic [CW-1:0] hi);
    logic [CW-1:0] c;
    c = v;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    clamp_off = c - lo;
  endfunction

endpackage

// File: hw/rtl/crop_box_iou_filter_top.sv
`timescale 1ns / 1ps

// channel   ports          accepted when
// in        in_*           in_valid && !in_stall
// out       out_*          out_valid && !out_stall
// cfg       cfg_*          cfg_we
//
// A box holds the back end through its area products and divisions; none to all
// of the divisions run (IoU and the left, top, right and bottom edges), each on
// the shared serial divider, and the areas are formed on one shared multiplier.
// Synchronous active-low reset clears control, the set flag and count.
// A two-beat queue parts intake from the divider; in_stall only when it is full.

module crop_box_iou_filter_top #(
  parameter int unsigned MAX_BOXES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] in_box_left,
  input  logic [16:0] in_box_top,
  input  logic [16:0] in_box_right,
  input  logic [16:0] in_box_bottom,
  input  logic [15:0] in_box_label,
  input  logic        in_set_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_iou_value,
  output logic        out_iou_pass,
  output logic        out_center_inside,
  output logic [16:0] out_norm_left,
  output logic [16:0] out_norm_top,
  output logic [16:0] out_norm_right,
  output logic [16:0] out_norm_bottom,
  output logic [15:0] out_class_id,
  output logic        out_set_all_pass,
  output logic [8:0]  out_set_kept_count,
  output logic        out_result_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  cbif_pkg::cfg_t     cfg_r;
  cbif_pkg::job_t     fr_job, head_job;
  logic               q_full, head_valid, pop;
  cbif_pkg::div_req_t div_req;
  cbif_pkg::div_rsp_t div_rsp;
  cbif_pkg::res_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= '0;
      cfg_r.top    <= '0;
      cfg_r.right  <= cbif_pkg::ONE_Q16;
      cfg_r.bottom <= cbif_pkg::ONE_Q16;
      cfg_r.thr    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbif_pkg::REG_CROP_LEFT:   cfg_r.left   <= cfg_data;
        cbif_pkg::REG_CROP_TOP:    cfg_r.top    <= cfg_data;
        cbif_pkg::REG_CROP_RIGHT:  cfg_r.right  <= cfg_data;
        cbif_pkg::REG_CROP_BOTTOM: cfg_r.bottom <= cfg_data;
        cbif_pkg::REG_MIN_IOU:     cfg_r.thr    <= cfg_data;
        default: ;
      endcase
    end
  end

  cbif_front u_front (
    .cfg        (cfg_r),
    .box_left   (in_box_left),
    .box_top    (in_box_top),
    .box_right  (in_box_right),
    .box_bottom (in_box_bottom),
    .box_label  (in_box_label),
    .set_last   (in_set_last),
    .job        (fr_job)
  );

  cbif_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_job   (fr_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  assign in_stall = q_full;

  cbif_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cbif_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .thr        (cfg_r.thr),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_iou_value      = res.iou_value;
  assign out_iou_pass       = res.iou_pass;
  assign out_center_inside  = res.center_inside;
  assign out_norm_left      = res.norm_left;
  assign out_norm_top       = res.norm_top;
  assign out_norm_right     = res.norm_right;
  assign out_norm_bottom    = res.norm_bottom;
  assign out_class_id       = res.class_id;
  assign out_set_all_pass   = res.set_all_pass;
  assign out_set_kept_count = res.set_kept_count;
  assign out_result_last    = res.result_last;

  a_not_kept_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_center_inside) |->
      (out_norm_left == '0 && out_norm_top == '0 &&
       out_norm_right == '0 && out_norm_bottom == '0))
    else $error("dropped box carries non-zero edges");

  a_set_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_last) |->
      (!out_set_all_pass && out_set_kept_count == '0))
    else $error("set summary outside a last beat");

  a_pass_iou: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_iou_pass) |-> (out_iou_value != '0))
    else $error("pass with zero IoU");

endmodule

// File: hw/rtl/cbif_front.sv
`timescale 1ns / 1ps

module cbif_front (
  input  cbif_pkg::cfg_t              cfg,
  input  logic [cbif_pkg::CW-1:0]     box_left,
  input  logic [cbif_pkg::CW-1:0]     box_top,
  input  logic [cbif_pkg::CW-1:0]     box_right,
  input  logic [cbif_pkg::CW-1:0]     box_bottom,
  input  logic [cbif_pkg::LW-1:0]     box_label,
  input  logic                        set_last,
  output cbif_pkg::job_t              job
);

  logic [cbif_pkg::CW:0] xs, ys, cl2, cr2, ct2, cb2;
  logic                  kept;

  always_comb begin
    xs   = {1'b0, box_left} + {1'b0, box_right};
    ys   = {1'b0, box_top} + {1'b0, box_bottom};
    cl2  = {cfg.left, 1'b0};
    cr2  = {cfg.right, 1'b0};
    ct2  = {cfg.top, 1'b0};
    cb2  = {cfg.bottom, 1'b0};
    kept = (xs > cl2) && (xs < cr2) && (ys > ct2) && (ys < cb2);

    job.iw    = cbif_pkg::span(cbif_pkg::umax(box_left, cfg.left),
                               cbif_pkg::umin(box_right, cfg.right));
    job.ih    = cbif_pkg::span(cbif_pkg::umax(box_top, cfg.top),
                               cbif_pkg::umin(box_bottom, cfg.bottom));
    job.bw    = cbif_pkg::span(box_left, box_right);
    job.bh    = cbif_pkg::span(box_top, box_bottom);
    job.cw    = cbif_pkg::span(cfg.left, cfg.right);
    job.ch    = cbif_pkg::span(cfg.top, cfg.bottom);
    job.off_l = cbif_pkg::clamp_off(box_left, cfg.left, cfg.right);
    job.off_t = cbif_pkg::clamp_off(box_top, cfg.top, cfg.bottom);
    job.off_r = cbif_pkg::clamp_off(box_right, cfg.left, cfg.right);
    job.off_b = cbif_pkg::clamp_off(box_bottom, cfg.top, cfg.bottom);
    job.kept  = kept;
    job.label = box_label;
    job.last  = set_last;
  end

endmodule

// File: hw/rtl/cbif_queue.sv
`timescale 1ns / 1ps

module cbif_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cbif_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cbif_pkg::job_t head_job
);

  cbif_pkg::job_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = ent_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/cbif_div.sv
`timescale 1ns / 1ps

// restoring divider, quotient of num*2^16/den with num <= den
module cbif_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cbif_pkg::div_req_t req,
  output cbif_pkg::div_rsp_t rsp
);

  logic                   busy_r, done_r;
  logic [4:0]             cnt_r;
  logic [cbif_pkg::DW:0]  rem_r;
  logic [cbif_pkg::DW-1:0] den_r;
  logic [cbif_pkg::QW-1:0] q_r;
  logic                   ge;
  logic [cbif_pkg::DW:0]  rem_sub;

  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= {rem_sub[cbif_pkg::DW-1:0], 1'b0};
      q_r   <= {q_r[cbif_pkg::QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(cbif_pkg::QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/cbif_back.sv
`timescale 1ns / 1ps

module cbif_back #(
  parameter int unsigned MAX_BOXES = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  cbif_pkg::job_t           head_job,
  output logic                     pop,
  input  logic [cbif_pkg::CW-1:0]  thr,
  output cbif_pkg::div_req_t       div_req,
  input  cbif_pkg::div_rsp_t       div_rsp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output cbif_pkg::res_t           res
);

  localparam int unsigned KEEP_CAP = (MAX_BOXES < 511) ? MAX_BOXES : 511;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_UNI  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } st_t;

  st_t                     st_r;
  logic [1:0]              mc_r;
  logic [2:0]              op_r;
  logic                    wait_r;
  logic [cbif_pkg::PW-1:0] inter_r, a1_r, a2_r;
  logic [cbif_pkg::DW-1:0] uni_r;
  logic [cbif_pkg::CW-1:0] q_r [cbif_pkg::N_DIV];
  logic [cbif_pkg::CW-1:0] ma, mb;
  logic [cbif_pkg::PW-1:0] prod;
  logic [cbif_pkg::DW-1:0] dnum, dden;
  logic                    skip;
  logic                    fail_r;
  logic [cbif_pkg::KW-1:0] kept_r;
  logic                    out_valid_r;
  cbif_pkg::res_t          res_r;
  logic                    load;
  logic                    pass, fail_nxt;
  logic [cbif_pkg::KW-1:0] kept_nxt;

  always_comb begin
    case (mc_r)
      2'd0:    begin ma = head_job.iw; mb = head_job.ih; end
      2'd1:    begin ma = head_job.bw; mb = head_job.bh; end
      default: begin ma = head_job.cw; mb = head_job.ch; end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    unique case (op_r)
      cbif_pkg::OP_IOU: begin
        dnum = {{(cbif_pkg::DW-cbif_pkg::PW){1'b0}}, inter_r};
        dden = uni_r;
      end
      cbif_pkg::OP_LEFT: begin
        dnum = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.off_l};
        dden = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.cw};
      end
      cbif_pkg::OP_TOP: begin
        dnum = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.off_t};
        dden = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.ch};
      end
      cbif_pkg::OP_RIGHT: begin
        dnum = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.off_r};
        dden = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.cw};
      end
      default: begin
        dnum = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.off_b};
        dden = {{(cbif_pkg::DW-cbif_pkg::CW){1'b0}}, head_job.ch};
      end
    endcase
    skip = (dden == '0) || ((op_r != cbif_pkg::OP_IOU) && !head_job.kept);
  end

  assign div_req.start = (st_r == ST_DIV) && !wait_r && !skip;
  assign div_req.num   = dnum;
  assign div_req.den   = dden;

  always_comb begin
    pass     = q_r[cbif_pkg::OP_IOU] > thr;
    fail_nxt = fail_r || !pass;
    kept_nxt = (head_job.kept && (kept_r < cbif_pkg::KW'(KEEP_CAP))) ?
               kept_r + cbif_pkg::KW'(1) : kept_r;
    load     = (st_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  assign pop       = load;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (st_r == ST_MUL) begin
      case (mc_r)
        2'd0:    inter_r <= prod;
        2'd1:    a1_r    <= prod;
        default: a2_r    <= prod;
      endcase
    end
    if (st_r == ST_UNI) begin
      uni_r <= {2'b0, a1_r} + {2'b0, a2_r} - {2'b0, inter_r};
    end
    if (st_r == ST_DIV) begin
      if (!wait_r && skip) q_r[op_r] <= '0;
      else if (wait_r && div_rsp.done) q_r[op_r] <= div_rsp.quo;
    end
    if (load) begin
      res_r.iou_value      <= q_r[cbif_pkg::OP_IOU];
      res_r.iou_pass       <= pass;
      res_r.center_inside  <= head_job.kept;
      res_r.norm_left      <= q_r[cbif_pkg::OP_LEFT];
      res_r.norm_top       <= q_r[cbif_pkg::OP_TOP];
      res_r.norm_right     <= q_r[cbif_pkg::OP_RIGHT];
      res_r.norm_bottom    <= q_r[cbif_pkg::OP_BOTTOM];
      res_r.class_id       <= head_job.label;
      res_r.set_all_pass   <= head_job.last && !fail_nxt;
      res_r.set_kept_count <= head_job.last ? kept_nxt : '0;
      res_r.result_last    <= head_job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mc_r        <= 2'd0;
      op_r        <= cbif_pkg::OP_IOU;
      wait_r      <= 1'b0;
      fail_r      <= 1'b0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          mc_r <= 2'd0;
          if (head_valid) st_r <= ST_MUL;
        end
        ST_MUL: begin
          mc_r <= mc_r + 2'd1;
          if (mc_r == 2'd2) st_r <= ST_UNI;
        end
        ST_UNI: begin
          op_r   <= cbif_pkg::OP_IOU;
          wait_r <= 1'b0;
          st_r   <= ST_DIV;
        end
        ST_DIV: begin
          if ((!wait_r && skip) || (wait_r && div_rsp.done)) begin
            wait_r <= 1'b0;
            if (op_r == cbif_pkg::OP_BOTTOM) st_r <= ST_DONE;
            else op_r <= op_r + 3'd1;
          end else if (!wait_r) begin
            wait_r <= 1'b1;
          end
        end
        ST_DONE: begin
          if (load) begin
            fail_r <= head_job.last ? 1'b0 : fail_nxt;
            kept_r <= head_job.last ? '0 : kept_nxt;
            st_r   <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule
